FILE: rtl/stack_machine_executor_defines.svh
// assertion macros for the stack machine executor
`ifndef STACK_MACHINE_EXECUTOR_DEFINES_SVH
`define STACK_MACHINE_EXECUTOR_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, off while reset is asserted
`define SME_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// checked property, also during reset
`define SME_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SME_ASSERT(label, prop, msg)
`define SME_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: rtl/sme_pkg.sv
`default_nettype none
package sme_pkg;
	// instruction codes
	localparam logic [2:0] CMD_LIT = 3'd0;
	localparam logic [2:0] CMD_ADD = 3'd1;
	localparam logic [2:0] CMD_SUB = 3'd2;
	localparam logic [2:0] CMD_MUL = 3'd3;
	localparam logic [2:0] CMD_DIV = 3'd4;
	localparam logic [2:0] CMD_SET = 3'd5;
	localparam logic [2:0] CMD_GET = 3'd6;
	localparam logic [2:0] CMD_SND = 3'd7;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_OVERFLOW = 3'd1;
	localparam logic [2:0] ST_UNDERFLOW = 3'd2;
	localparam logic [2:0] ST_DIVZERO  = 3'd3;
	localparam logic [2:0] ST_BADINDEX = 3'd4;
	localparam logic [2:0] ST_IGNORED  = 3'd5;

	localparam logic [31:0] ENT0_INIT = 32'd100;
	localparam logic [31:0] ENT1_INIT = 32'd80;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] immediate;
		logic               program_start;
	} item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] top_value;
		logic [7:0]         depth;
		logic               sound_valid;
		logic signed [31:0] sound_id;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic       load_in;
		logic       rd_top;
		logic       rd_second;
		logic       push_imm;
		logic       write_alu;
		logic       start_div;
		logic       write_div;
		logic       set_entry;
		logic       ent_rd;
		logic       write_ent;
		logic       pop1;
		logic       snd;
		logic       set_fault;
		logic       status_we;
		logic [2:0] status;
		logic       load_out;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] cmd;
		logic       fault;
		logic       sp_zero;
		logic       sp_lt2;
		logic       sp_full;
		logic       b_zero;
		logic       idx_ok_a;
		logic       idx_ok_b;
		logic       div_done;
		logic       out_free;
	} dp_stat_t;

	// power-up value of an entity entry
	function automatic logic [31:0] ent_init(input logic [31:0] idx);
		logic [31:0] v;
		v = 32'd0;
		if (idx == 32'd0)
			v = ENT0_INIT;
		else if (idx == 32'd1)
			v = ENT1_INIT;
		return v;
	endfunction
endpackage
`default_nettype wire

FILE: rtl/sme_div.sv
`default_nettype none
module sme_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [31:0]      quotient
);
	import sme_pkg::*;

	// restoring divide on magnitudes, one quotient bit per cycle
	logic [31:0] rem_q, quo_q, den_q;
	logic [4:0]  cnt_q;
	logic        busy_q, neg_q, done_q;
	logic [32:0] shifted, trial;

	assign shifted = {rem_q, quo_q[31]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[31] ? (32'd0 - dividend) : dividend;
			den_q <= divisor[31] ? (32'd0 - divisor) : divisor;
			neg_q <= dividend[31] ^ divisor[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (32'd0 - quo_q) : quo_q;
endmodule
`default_nettype wire

FILE: rtl/sme_ctrl.sv
`default_nettype none
module sme_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire sme_pkg::dp_stat_t stat,
	output sme_pkg::dp_cmd_t       ctl
);
	import sme_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_DEC  = 9'b000000010,
		S_RDB  = 9'b000000100,
		S_RDA  = 9'b000001000,
		S_EXEC = 9'b000010000,
		S_DIVW = 9'b000100000,
		S_GET  = 9'b001000000,
		S_RDT  = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		ctl      = '0;
		ctl.status = ST_OK;
		state_d  = state_q;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load_in = 1'b1;
					state_d     = S_DEC;
				end
			end
			S_DEC: begin
				state_d = S_RDT;
				if (stat.fault) begin
					ctl.status_we = 1'b1;
					ctl.status    = ST_IGNORED;
				end else begin
					case (stat.cmd)
						CMD_LIT: begin
							if (stat.sp_full) begin
								ctl.status_we = 1'b1;
								ctl.status    = ST_OVERFLOW;
								ctl.set_fault = 1'b1;
							end else
								ctl.push_imm = 1'b1;
						end
						CMD_GET, CMD_SND: begin
							if (stat.sp_zero) begin
								ctl.status_we = 1'b1;
								ctl.status    = ST_UNDERFLOW;
								ctl.set_fault = 1'b1;
							end else
								state_d = S_RDB;
						end
						default: begin
							if (stat.sp_lt2) begin
								ctl.status_we = 1'b1;
								ctl.status    = ST_UNDERFLOW;
								ctl.set_fault = 1'b1;
							end else
								state_d = S_RDB;
						end
					endcase
				end
			end
			S_RDB: begin
				ctl.rd_top = 1'b1;
				state_d    = S_RDA;
			end
			S_RDA: begin
				ctl.rd_second = 1'b1;
				state_d       = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_RDT;
				case (stat.cmd)
					CMD_ADD, CMD_SUB, CMD_MUL: ctl.write_alu = 1'b1;
					CMD_DIV: begin
						if (stat.b_zero) begin
							ctl.status_we = 1'b1;
							ctl.status    = ST_DIVZERO;
							ctl.set_fault = 1'b1;
						end else begin
							ctl.start_div = 1'b1;
							state_d       = S_DIVW;
						end
					end
					CMD_SET: begin
						ctl.set_entry = 1'b1;
						if (!stat.idx_ok_a) begin
							ctl.status_we = 1'b1;
							ctl.status    = ST_BADINDEX;
						end
					end
					CMD_GET: begin
						if (stat.idx_ok_b) begin
							ctl.ent_rd = 1'b1;
							state_d    = S_GET;
						end else begin
							ctl.pop1      = 1'b1;
							ctl.status_we = 1'b1;
							ctl.status    = ST_BADINDEX;
						end
					end
					CMD_SND: begin
						ctl.pop1 = 1'b1;
						ctl.snd  = 1'b1;
					end
					default: ;
				endcase
			end
			S_DIVW: begin
				if (stat.div_done) begin
					ctl.write_div = 1'b1;
					state_d       = S_RDT;
				end
			end
			S_GET: begin
				ctl.write_ent = 1'b1;
				state_d       = S_RDT;
			end
			S_RDT: begin
				ctl.rd_top = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					ctl.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/sme_dpath.sv
`default_nettype none
`include "stack_machine_executor_defines.svh"
module sme_dpath #(
	parameter int STACK_DEPTH  = 128,
	parameter int ENTITY_COUNT = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sme_pkg::item_t   in_data,
	input  wire sme_pkg::dp_cmd_t ctl,
	output sme_pkg::dp_stat_t     stat,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output sme_pkg::result_t      out_data
);
	import sme_pkg::*;

	localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int EW  = (ENTITY_COUNT > 1) ? $clog2(ENTITY_COUNT) : 1;
	localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

	logic [31:0] stack_mem [STACK_DEPTH];
	logic [31:0] ent_mem [ENTITY_COUNT];
	logic [ENTITY_COUNT-1:0] ent_vld_q;

	logic [2:0]     cmd_q, status_q;
	logic [31:0]    imm_q, rdata_q, b_q, snd_id_q, ent_rd_q, ent_def_q;
	logic [SPW-1:0] sp_q, sp_m1, sp_m2;
	logic           fault_q, snd_q, ent_vld_rd_q, out_valid_q;
	result_t        out_q;

	logic [31:0]    a, alu_r, div_q, ent_val, wdata;
	logic [AW-1:0]  waddr, raddr;
	logic           we, div_done, ok_a, ok_b;

	assign a     = rdata_q;
	assign sp_m1 = sp_q - SPW'(1);
	assign sp_m2 = sp_q - SPW'(2);
	assign ok_a  = !a[31] && (a < 32'(ENTITY_COUNT));
	assign ok_b  = !b_q[31] && (b_q < 32'(ENTITY_COUNT));

	always_comb begin
		case (cmd_q)
			CMD_ADD: alu_r = a + b_q;
			CMD_SUB: alu_r = a - b_q;
			default: alu_r = a * b_q;
		endcase
	end

	sme_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.start_div),
		.dividend (a),
		.divisor  (b_q),
		.done     (div_done),
		.quotient (div_q)
	);

	assign ent_val = ent_vld_rd_q ? ent_rd_q : ent_def_q;

	// stack write port and read address
	always_comb begin
		we    = ctl.push_imm | ctl.write_alu | ctl.write_div | ctl.write_ent;
		waddr = sp_q[AW-1:0];
		wdata = imm_q;
		if (ctl.write_alu) begin
			waddr = sp_m2[AW-1:0];
			wdata = alu_r;
		end else if (ctl.write_div) begin
			waddr = sp_m2[AW-1:0];
			wdata = div_q;
		end else if (ctl.write_ent) begin
			waddr = sp_m1[AW-1:0];
			wdata = ent_val;
		end
		raddr = ctl.rd_second ? sp_m2[AW-1:0] : sp_m1[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (we)
			stack_mem[waddr] <= wdata;
		if (ctl.rd_top | ctl.rd_second)
			rdata_q <= stack_mem[raddr];
		if (ctl.rd_second)
			b_q <= rdata_q;
		if (ctl.set_entry && ok_a)
			ent_mem[a[EW-1:0]] <= b_q;
		if (ctl.ent_rd) begin
			ent_rd_q     <= ent_mem[b_q[EW-1:0]];
			ent_vld_rd_q <= ent_vld_q[b_q[EW-1:0]];
			ent_def_q    <= ent_init(b_q);
		end
		if (ctl.load_in) begin
			cmd_q <= in_data.cmd;
			imm_q <= in_data.immediate;
		end
		if (ctl.snd)
			snd_id_q <= b_q;
		if (ctl.load_out) begin
			out_q.status      <= status_q;
			out_q.top_value   <= (sp_q == '0) ? 32'sd0 : rdata_q;
			out_q.depth       <= 8'(sp_q);
			out_q.sound_valid <= snd_q;
			out_q.sound_id    <= snd_q ? snd_id_q : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			fault_q     <= 1'b0;
			status_q    <= ST_OK;
			snd_q       <= 1'b0;
			ent_vld_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.load_in) begin
				status_q <= ST_OK;
				snd_q    <= 1'b0;
				if (in_data.program_start) begin
					sp_q    <= '0;
					fault_q <= 1'b0;
				end
			end
			if (ctl.push_imm)
				sp_q <= sp_q + SPW'(1);
			else if (ctl.write_alu | ctl.write_div | ctl.pop1)
				sp_q <= sp_m1;
			else if (ctl.set_entry)
				sp_q <= sp_m2;
			if (ctl.set_fault)
				fault_q <= 1'b1;
			if (ctl.status_we)
				status_q <= ctl.status;
			if (ctl.snd)
				snd_q <= 1'b1;
			if (ctl.set_entry && ok_a)
				ent_vld_q[a[EW-1:0]] <= 1'b1;
			if (ctl.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		stat          = '0;
		stat.cmd      = cmd_q;
		stat.fault    = fault_q;
		stat.sp_zero  = (sp_q == '0);
		stat.sp_lt2   = (sp_q < SPW'(2));
		stat.sp_full  = (sp_q >= SP_FULL);
		stat.b_zero   = (b_q == 32'd0);
		stat.idx_ok_a = ok_a;
		stat.idx_ok_b = ok_b;
		stat.div_done = div_done;
		stat.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`SME_ASSERT_ALWAYS(a_sp_bound, !arst_n || sp_q <= SP_FULL, "stack pointer beyond depth")
	`SME_ASSERT(a_fault_src, $rose(fault_q) |-> $past(ctl.set_fault), "fault without cause")
	`SME_ASSERT(a_snd_ok, out_valid_q && out_q.sound_valid |-> out_q.status == ST_OK,
		"sound reported with error status")
	`SME_ASSERT(a_out_hold, ctl.load_out |-> !out_valid_q || !out_stall,
		"result overwritten while held")
endmodule
`default_nettype wire

FILE: rtl/stack_machine_executor.sv
// flow: literal, faulted and ignored transactions go from decode to top read and output;
// add, sub, mul, set, sound and bad get first read both operands and execute, get then reads
// the entity table, divide waits on the 32-step divider; one transaction at a time, and the
// next accept comes only after the result is registered, later while a held result blocks
// a result waiting in the output register does not block the next accept
// reset: arst_n async active low; empties stack, clears fault, entity table back to 100 and 80
`default_nettype none
module stack_machine_executor #(
	parameter int STACK_DEPTH  = 128,
	parameter int ENTITY_COUNT = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire sme_pkg::item_t   in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output sme_pkg::result_t      out_data
);
	import sme_pkg::*;

	// command and status between sequencer and datapath
	dp_cmd_t  ctl;
	dp_stat_t stat;

	// sequencer: decode, operand fetch from stack memory, execute, top refresh
	sme_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	// datapath: stack memory, entity table, alu, divider, result register
	sme_dpath #(
		.STACK_DEPTH  (STACK_DEPTH),
		.ENTITY_COUNT (ENTITY_COUNT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.ctl       (ctl),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);
endmodule
`default_nettype wire
